// File: design/ltp_pkg.sv
// Package for the loop time profiler: request and response word types,
// function codes and capture phase codes. No dependencies.
package ltp_pkg;

   localparam logic [2:0] FUNC_START     = 3'd0;
   localparam logic [2:0] FUNC_SET_IDLE  = 3'd1;
   localparam logic [2:0] FUNC_LOOP_MARK = 3'd2;
   localparam logic [2:0] FUNC_MOD_TIME  = 3'd3;
   localparam logic [2:0] FUNC_READ      = 3'd4;

   localparam logic [1:0] PHASE_IDLE = 2'd0;
   localparam logic [1:0] PHASE_RUN  = 2'd1;
   localparam logic [1:0] PHASE_DONE = 2'd2;

   localparam logic [31:0] WINDOW_RESET = 32'd1000;

   typedef struct packed {
      logic [2:0]  func;
      logic [31:0] now_ms;
      logic [2:0]  module_index;
      logic [31:0] elapsed_us;
      logic [4:0]  stat_index;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  capture_state;
      logic [31:0] window_value;
      logic [31:0] stat_value;
   } rsp_word_type;

endpackage

// File: design/loop_time_profiler_core.sv
// Loop time profiler core: capture state, log2 loop period histogram and
// per-module time sums. Depends on ltp_pkg.
//
// Usage: each request word carries a function code (start, set idle, loop
// mark, module time, read). The block updates its statistics and returns
// exactly one response word per request: the capture state, the window
// value and one statistic chosen by stat_index, all taken after the update.
// A request is taken when req_valid is high and req_stall is low; a response
// is taken when rsp_valid is high and rsp_stall is low. The capture window
// register is written over the csr channel, which is always ready.
// Throughput is one word per cycle while rsp_stall stays low, set by the
// single update stage; the whole update and statistic select run between
// the state registers and the response register.
// A two-entry response buffer lets one more request in while a response is
// stalled; req_stall rises only when both entries are full.
// Reset clears all statistics, sets the phase to idle and the window to 1000.
module loop_time_profiler_core
   import ltp_pkg::*;
#(
   parameter int NUM_BUCKETS = 8,
   parameter int NUM_MODULES = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [31:0]  csr_data
);

   localparam int BKT_IDX_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int MOD_IDX_W = (NUM_MODULES > 1) ? $clog2(NUM_MODULES) : 1;
   localparam logic [6:0] STAT_OVER  = 7'(NUM_BUCKETS);
   localparam logic [6:0] STAT_TOTAL = 7'(NUM_BUCKETS + 1);
   localparam logic [6:0] STAT_LONG  = 7'(NUM_BUCKETS + 2);
   localparam logic [6:0] STAT_DUR   = 7'(NUM_BUCKETS + 3);
   localparam logic [6:0] STAT_MOD   = 7'(NUM_BUCKETS + 4);
   localparam logic [6:0] STAT_END   = 7'(NUM_BUCKETS + 4 + NUM_MODULES);

   logic [31:0] window_ff, window_in;
   logic [1:0]  phase_ff, phase_in;
   logic        have_start_ff, have_start_in;
   logic [31:0] last_mark_ff, last_mark_in;
   logic [31:0] time_left_ff, time_left_in;
   logic [31:0] bucket_ff [NUM_BUCKETS];
   logic [31:0] bucket_in [NUM_BUCKETS];
   logic [31:0] over_ff, over_in;
   logic [31:0] total_ff, total_in;
   logic [31:0] longest_ff, longest_in;
   logic [31:0] dur_ff, dur_in;
   logic [31:0] mod_ff [NUM_MODULES];
   logic [31:0] mod_in [NUM_MODULES];

   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff, out_word_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_word_type skid_word_ff, skid_word_in;

   logic         accept;
   logic         is_start;
   logic         timed_mark;
   logic         mod_event;
   logic [31:0]  passed;
   logic         over_hit;
   logic [NUM_BUCKETS-1:0] bkt_hit;
   logic [6:0]   stat_idx;
   logic [6:0]   mod_ofs;
   logic [31:0]  stat_val;
   logic [31:0]  window_val;
   rsp_word_type new_word;
   logic         out_free;

   assign accept    = req_valid && !req_stall;
   assign req_stall = skid_valid_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   assign is_start   = accept && (req_word.func == FUNC_START);
   assign timed_mark = accept && (req_word.func == FUNC_LOOP_MARK) &&
                       (phase_ff == PHASE_RUN) && have_start_ff;
   assign mod_event  = accept && (req_word.func == FUNC_MOD_TIME) &&
                       (phase_ff == PHASE_RUN);
   assign passed     = req_word.now_ms - last_mark_ff;
   assign over_hit   = {1'b0, passed} > (33'd1 << NUM_BUCKETS);

   always_comb begin
      for (int i = 0; i < NUM_BUCKETS; i++) begin
         if (i == 0) begin
            bkt_hit[i] = {1'b0, passed} <= 33'd2;
         end else begin
            bkt_hit[i] = ({1'b0, passed} > (33'd1 << i)) &&
                         ({1'b0, passed} <= (33'd2 << i));
         end
      end
   end

   always_comb begin
      window_in     = window_ff;
      phase_in      = phase_ff;
      have_start_in = have_start_ff;
      last_mark_in  = last_mark_ff;
      time_left_in  = time_left_ff;
      over_in       = over_ff;
      total_in      = total_ff;
      longest_in    = longest_ff;
      dur_in        = dur_ff;
      if (csr_valid && csr_ready) begin
         window_in = csr_data;
      end
      if (is_start) begin
         time_left_in  = window_ff;
         phase_in      = PHASE_RUN;
         have_start_in = 1'b0;
         over_in       = '0;
         total_in      = '0;
         longest_in    = '0;
         dur_in        = '0;
      end else if (accept && req_word.func == FUNC_SET_IDLE) begin
         phase_in = PHASE_IDLE;
      end else if (accept && req_word.func == FUNC_LOOP_MARK &&
                   phase_ff == PHASE_RUN && !have_start_ff) begin
         have_start_in = 1'b1;
         last_mark_in  = req_word.now_ms;
      end else if (timed_mark) begin
         total_in = total_ff + 32'd1;
         if (over_hit) begin
            over_in = over_ff + 32'd1;
         end
         if (longest_ff < passed) begin
            longest_in = passed;
         end
         dur_in = dur_ff + passed;
         if (time_left_ff <= passed) begin
            time_left_in = '0;
            phase_in     = PHASE_DONE;
         end else begin
            time_left_in = time_left_ff - passed;
            last_mark_in = req_word.now_ms;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_BUCKETS; i++) begin
         if (is_start) begin
            bucket_in[i] = '0;
         end else if (timed_mark && bkt_hit[i]) begin
            bucket_in[i] = bucket_ff[i] + 32'd1;
         end else begin
            bucket_in[i] = bucket_ff[i];
         end
      end
      for (int m = 0; m < NUM_MODULES; m++) begin
         if (is_start) begin
            mod_in[m] = '0;
         end else if (mod_event && (32'(req_word.module_index) == 32'(m))) begin
            mod_in[m] = mod_ff[m] + req_word.elapsed_us;
         end else begin
            mod_in[m] = mod_ff[m];
         end
      end
   end

   assign stat_idx = {2'b00, req_word.stat_index};
   assign mod_ofs  = stat_idx - STAT_MOD;

   always_comb begin
      stat_val = '0;
      if (stat_idx < STAT_OVER) begin
         stat_val = bucket_in[BKT_IDX_W'(stat_idx)];
      end else if (stat_idx == STAT_OVER) begin
         stat_val = over_in;
      end else if (stat_idx == STAT_TOTAL) begin
         stat_val = total_in;
      end else if (stat_idx == STAT_LONG) begin
         stat_val = longest_in;
      end else if (stat_idx == STAT_DUR) begin
         stat_val = dur_in;
      end else if (stat_idx < STAT_END) begin
         stat_val = mod_in[MOD_IDX_W'(mod_ofs)];
      end
   end

   always_comb begin
      case (phase_in)
         PHASE_RUN:  window_val = time_left_in;
         PHASE_IDLE: window_val = window_ff;
         default:    window_val = dur_in;
      endcase
   end

   assign new_word.capture_state = phase_in;
   assign new_word.window_value  = window_val;
   assign new_word.stat_value    = stat_val;

   // Two-entry response buffer; the skid entry fills only while the
   // output entry is held by the receiver.
   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept;
            out_word_in  = new_word;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_word_in  = new_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff     <= WINDOW_RESET;
         phase_ff      <= PHASE_IDLE;
         have_start_ff <= 1'b0;
         last_mark_ff  <= '0;
         time_left_ff  <= '0;
         over_ff       <= '0;
         total_ff      <= '0;
         longest_ff    <= '0;
         dur_ff        <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_BUCKETS; i++) begin
            bucket_ff[i] <= '0;
         end
         for (int m = 0; m < NUM_MODULES; m++) begin
            mod_ff[m] <= '0;
         end
      end else begin
         window_ff     <= window_in;
         phase_ff      <= phase_in;
         have_start_ff <= have_start_in;
         last_mark_ff  <= last_mark_in;
         time_left_ff  <= time_left_in;
         over_ff       <= over_in;
         total_ff      <= total_in;
         longest_ff    <= longest_in;
         dur_ff        <= dur_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         for (int i = 0; i < NUM_BUCKETS; i++) begin
            bucket_ff[i] <= bucket_in[i];
         end
         for (int m = 0; m < NUM_MODULES; m++) begin
            mod_ff[m] <= mod_in[m];
         end
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("Skid entry holds a word while the output entry is empty.");

   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      is_start |=> (phase_ff == PHASE_RUN))
      else $error("A start word did not enter the in-progress phase.");

   a_done_no_time: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PHASE_DONE) |-> (time_left_ff == 32'd0))
      else $error("Capture is done with time left.");

   a_accept_shows: assert property (@(posedge clock) disable iff (reset)
      (accept && !out_valid_ff) |=> out_valid_ff)
      else $error("An accepted word produced no response.");

endmodule
